// File: rtl/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types and register codes for the environmental sensor compensation.
// ----------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

    typedef struct packed {
        logic [19:0] adc_temp;
        logic [19:0] adc_press;
        logic [15:0] adc_hum;
    } esc_in_t;

    typedef struct packed {
        logic signed [31:0] temperature;
        logic [31:0]        pressure;
        logic [16:0]        humidity;
        logic               temperature_valid;
        logic               pressure_valid;
        logic               humidity_valid;
        logic               status;
    } esc_out_t;

    typedef enum logic [2:0] {
        REG_CHANNEL_ENABLE   = 3'd0,
        REG_CALIB_TEMP       = 3'd1,
        REG_CALIB_PRESS_LOW  = 3'd2,
        REG_CALIB_PRESS_HIGH = 3'd3,
        REG_CALIB_MIXED      = 3'd4,
        REG_CALIB_HUM        = 3'd5
    } esc_reg_t;

    localparam int DivStages = 33;

    // 32-bit wrapping multiply, low word kept
    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        begin
            p = a * b;
            return p[31:0];
        end
    endfunction

    function automatic logic [31:0] asr(input logic [31:0] x, input int s);
        return $unsigned($signed(x) >>> s);
    endfunction

endpackage

`default_nettype wire

// File: rtl/esc_div.sv
// ----------------------------------------------------------------------------
// esc_div
// Pipelined unsigned 32/32 restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             out_valid,
    output logic [31:0]      quotient
);
    import esc_pkg::*;

    logic [31:0] rem_reg [0:32];
    logic [31:0] quo_reg [0:32];
    logic [31:0] dvs_reg [0:32];
    logic [32:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[31:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= '0;
        quo_reg[0] <= dividend;
        dvs_reg[0] <= divisor;
    end

    // each stage: shift in one dividend bit, trial subtract
    for (genvar i = 0; i < 32; i++) begin : g_stage
        logic [32:0] trial;
        logic [32:0] rsh;
        assign rsh   = {rem_reg[i], quo_reg[i][31]};
        assign trial = rsh - {1'b0, dvs_reg[i]};
        always_ff @(posedge clk)
        begin
            dvs_reg[i+1] <= dvs_reg[i];
            if (!trial[32])
            begin
                rem_reg[i+1] <= trial[31:0];
                quo_reg[i+1] <= {quo_reg[i][30:0], 1'b1};
            end
            else
            begin
                rem_reg[i+1] <= rsh[31:0];
                quo_reg[i+1] <= {quo_reg[i][30:0], 1'b0};
            end
        end
    end

    assign out_valid = vld_reg[DivStages-1];
    assign quotient  = quo_reg[32];

endmodule

`default_nettype wire

// File: rtl/esc_front.sv
// ----------------------------------------------------------------------------
// esc_front
// Temperature, t_fine and humidity stages, and the pressure terms up to the
// divider operands.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire esc_pkg::esc_in_t   in_data,
    input  wire logic [2:0]         enable,
    input  wire logic [47:0]        calib_temp,
    input  wire logic [63:0]        calib_press_low,
    input  wire logic [47:0]        calib_mixed,
    input  wire logic [31:0]        calib_hum,
    input  wire logic [63:0]        p56_in,
    output logic                    out_valid,
    output esc_pkg::esc_out_t       out_data,
    output logic [31:0]             dividend,
    output logic [31:0]             divisor,
    output logic                    big_p
);
    import esc_pkg::*;

    logic [31:0] t1, t2, t3, p1, p2, p3, p4, h1, h2, h3, h4, h5, h6;
    assign t1 = {16'd0, calib_temp[15:0]};
    assign t2 = {{16{calib_temp[31]}}, calib_temp[31:16]};
    assign t3 = {{16{calib_temp[47]}}, calib_temp[47:32]};
    assign p1 = {16'd0, calib_press_low[15:0]};
    assign p2 = {{16{calib_press_low[31]}}, calib_press_low[31:16]};
    assign p3 = {{16{calib_press_low[47]}}, calib_press_low[47:32]};
    assign p4 = {{16{calib_press_low[63]}}, calib_press_low[63:48]};
    assign h1 = {24'd0, calib_mixed[23:16]};
    assign h2 = {{16{calib_mixed[39]}}, calib_mixed[39:24]};
    assign h3 = {24'd0, calib_mixed[47:40]};
    assign h4 = {{20{calib_hum[11]}}, calib_hum[11:0]};
    assign h5 = {{20{calib_hum[23]}}, calib_hum[23:12]};
    assign h6 = {{24{calib_hum[31]}}, calib_hum[31:24]};

    // P5/P6 come from the high bank through the top, already sign-extended
    logic [31:0] p5_l, p6_l;
    assign p5_l = p56_in[31:0];
    assign p6_l = p56_in[63:32];

    // stage 1: temperature products
    logic        v1_reg;
    esc_in_t     in1_reg;
    logic [2:0]  en1_reg;
    logic [31:0] tv1_reg, dd_reg;
    logic [31:0] d1;
    assign d1 = {16'd0, in_data.adc_temp[19:4]} - t1;

    // stage 2: t_fine terms
    logic        v2_reg;
    esc_in_t     in2_reg;
    logic [2:0]  en2_reg;
    logic [31:0] tv1b_reg, tv2_reg;

    // stage 3: t_fine, derived terms
    logic        v3_reg;
    esc_in_t     in3_reg;
    logic [2:0]  en3_reg;
    logic [31:0] tfine_reg;

    // stage 4: first-level products
    logic        v4_reg;
    esc_in_t     in4_reg;
    logic [2:0]  en4_reg;
    logic [31:0] tmp5_reg, pv1_reg, qq_reg;
    logic [31:0] ha_reg, hb6_reg, hb3_reg;

    logic [31:0] pv1_n, q_n, hv_n, tfine_n;
    assign tfine_n = tv1b_reg + tv2_reg;
    assign pv1_n   = asr(tfine_reg, 1) - 32'd64000;
    assign q_n     = asr(pv1_n, 2);
    assign hv_n    = tfine_reg - 32'd76800;

    // stage 5: second-level
    logic        v5_reg;
    esc_in_t     in5_reg;
    logic [2:0]  en5_reg;
    logic [31:0] temp5_reg;
    logic [31:0] v2a_reg, v2b_reg, p3q_reg, p2v_reg, ha5_reg, hb1_reg, hb2_reg;

    // stage 6
    logic        v6_reg;
    esc_in_t     in6_reg;
    logic [2:0]  en6_reg;
    logic [31:0] temp6_reg, v2_6_reg, pv1_6_reg, ha6_reg, hbp_reg;

    // stage 7
    logic        v7_reg;
    esc_in_t     in7_reg;
    logic [2:0]  en7_reg;
    logic [31:0] temp7_reg, v2_7_reg, pm_reg, ha7_reg, hbs_reg;

    // stage 8
    logic        v8_reg;
    logic [2:0]  en8_reg;
    logic [31:0] temp8_reg, pp_reg, pm8_reg, ha8_reg, hb8_reg;

    // stage 9
    logic        v9_reg;
    logic [2:0]  en9_reg;
    logic [31:0] temp9_reg, pp9_reg, pm9_reg, r_reg;

    // stage 10
    logic        v10_reg;
    logic [2:0]  en10_reg;
    logic [31:0] temp10_reg, pp10_reg, pm10_reg, r10_reg, rr_reg;

    // stage 11
    logic        v11_reg;
    logic [2:0]  en11_reg;
    logic [31:0] temp11_reg, pp11_reg, pm11_reg, r11_reg, rrh_reg;

    logic [31:0] r15_n, rfin, hum_n;
    assign r15_n = asr(r_reg, 15);
    assign rfin  = r11_reg - asr(rrh_reg, 4);
    always_comb
    begin
        if (rfin[31])
            hum_n = '0;
        else if (rfin > 32'd419430400)
            hum_n = 32'd102400;
        else
            hum_n = {12'd0, rfin[31:12]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0; v4_reg <= 1'b0;
            v5_reg <= 1'b0; v6_reg <= 1'b0; v7_reg <= 1'b0; v8_reg <= 1'b0;
            v9_reg <= 1'b0; v10_reg <= 1'b0; v11_reg <= 1'b0; out_valid <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid; v2_reg <= v1_reg; v3_reg <= v2_reg;
            v4_reg <= v3_reg; v5_reg <= v4_reg; v6_reg <= v5_reg;
            v7_reg <= v6_reg; v8_reg <= v7_reg; v9_reg <= v8_reg;
            v10_reg <= v9_reg; v11_reg <= v10_reg; out_valid <= v11_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        in1_reg <= in_data;
        en1_reg <= enable;
        tv1_reg <= mul32({15'd0, in_data.adc_temp[19:3]} - {t1[30:0], 1'b0}, t2);
        dd_reg  <= mul32(d1, d1);

        in2_reg  <= in1_reg;
        en2_reg  <= en1_reg;
        tv1b_reg <= asr(tv1_reg, 11);
        tv2_reg  <= asr(mul32(asr(dd_reg, 12), t3), 14);

        in3_reg   <= in2_reg;
        en3_reg   <= en2_reg;
        tfine_reg <= tfine_n;

        in4_reg    <= in3_reg;
        en4_reg    <= en3_reg;
        tmp5_reg   <= mul32(tfine_reg, 32'd5);
        pv1_reg    <= pv1_n;
        qq_reg     <= mul32(q_n, q_n);
        ha_reg     <= {2'd0, in3_reg.adc_hum, 14'd0} - {h4[11:0], 20'd0} -
                      mul32(h5, hv_n) + 32'd16384;
        hb6_reg    <= mul32(hv_n, h6);
        hb3_reg    <= mul32(hv_n, h3);

        in5_reg   <= in4_reg;
        en5_reg   <= en4_reg;
        temp5_reg <= asr(tmp5_reg + 32'd128, 8);
        v2a_reg   <= mul32(asr(qq_reg, 11), p6_l);
        v2b_reg   <= {mul32(pv1_reg, p5_l)} << 1;
        p3q_reg   <= mul32(p3, asr(qq_reg, 13));
        p2v_reg   <= mul32(p2, pv1_reg);
        ha5_reg   <= asr(ha_reg, 15);
        hb1_reg   <= asr(hb6_reg, 10);
        hb2_reg   <= asr(hb3_reg, 11) + 32'd32768;

        in6_reg   <= in5_reg;
        en6_reg   <= en5_reg;
        temp6_reg <= temp5_reg;
        v2_6_reg  <= asr(v2a_reg + v2b_reg, 2) + {p4[15:0], 16'd0};
        pv1_6_reg <= asr(asr(p3q_reg, 3) + asr(p2v_reg, 1), 18);
        ha6_reg   <= ha5_reg;
        hbp_reg   <= mul32(hb1_reg, hb2_reg);

        in7_reg   <= in6_reg;
        en7_reg   <= en6_reg;
        temp7_reg <= temp6_reg;
        v2_7_reg  <= v2_6_reg;
        pm_reg    <= mul32(32'd32768 + pv1_6_reg, p1);
        ha7_reg   <= ha6_reg;
        hbs_reg   <= asr(hbp_reg, 10) + 32'd2097152;

        en8_reg   <= en7_reg;
        temp8_reg <= temp7_reg;
        pp_reg    <= mul32((32'd1048576 - {12'd0, in7_reg.adc_press}) - asr(v2_7_reg, 12),
                           32'd3125);
        pm8_reg   <= asr(pm_reg, 15);
        ha8_reg   <= ha7_reg;
        hb8_reg   <= asr(mul32(hbs_reg, h2) + 32'd8192, 14);

        en9_reg   <= en8_reg;
        temp9_reg <= temp8_reg;
        pp9_reg   <= pp_reg;
        pm9_reg   <= pm8_reg;
        r_reg     <= mul32(ha8_reg, hb8_reg);

        en10_reg   <= en9_reg;
        temp10_reg <= temp9_reg;
        pp10_reg   <= pp9_reg;
        pm10_reg   <= pm9_reg;
        r10_reg    <= r_reg;
        rr_reg     <= asr(mul32(r15_n, r15_n), 7);

        en11_reg   <= en10_reg;
        temp11_reg <= temp10_reg;
        pp11_reg   <= pp10_reg;
        pm11_reg   <= pm10_reg;
        r11_reg    <= r10_reg;
        rrh_reg    <= mul32(rr_reg, h1);

        out_data.status            <= ~en11_reg[0];
        out_data.temperature_valid <= en11_reg[0];
        out_data.pressure_valid    <= en11_reg[0] & en11_reg[1];
        out_data.humidity_valid    <= en11_reg[0] & en11_reg[2];
        out_data.temperature       <= en11_reg[0] ? temp11_reg : '0;
        out_data.pressure          <= '0;
        out_data.humidity          <= (en11_reg[0] & en11_reg[2]) ? hum_n[16:0] : '0;
        big_p    <= pp11_reg[31];
        dividend <= pp11_reg[31] ? pp11_reg : {pp11_reg[30:0], 1'b0};
        divisor  <= pm11_reg;
    end

endmodule

`default_nettype wire

// File: rtl/esc_back.sv
// ----------------------------------------------------------------------------
// esc_back
// Pressure correction after the divider: P7, P8, P9 terms.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire esc_pkg::esc_out_t  in_data,
    input  wire logic               big_p,
    input  wire logic               div_zero,
    input  wire logic [31:0]        quotient,
    input  wire logic [63:0]        calib_press_high,
    input  wire logic [15:0]        calib_p9,
    output logic                    out_valid,
    output esc_pkg::esc_out_t       out_data
);
    import esc_pkg::*;

    logic [31:0] p7, p8, p9, p_n;
    assign p7 = {{16{calib_press_high[47]}}, calib_press_high[47:32]};
    assign p8 = {{16{calib_press_high[63]}}, calib_press_high[63:48]};
    assign p9 = {{16{calib_p9[15]}}, calib_p9};
    assign p_n = big_p ? {quotient[30:0], 1'b0} : quotient;

    logic        v1_reg, v2_reg, v3_reg;
    esc_out_t    d1_reg, d2_reg, d3_reg;
    logic        z1_reg, z2_reg, z3_reg;
    logic [31:0] p1_reg, p2_reg, p3_reg, sq_reg, a_reg, b_reg;
    logic [31:0] p3s, sq_full;
    assign p3s     = {3'd0, p1_reg[31:3]};
    assign sq_full = mul32(p3s, p3s);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0; out_valid <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid; v2_reg <= v1_reg; v3_reg <= v2_reg;
            out_valid <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d1_reg <= in_data; z1_reg <= div_zero; p1_reg <= p_n;
        d2_reg <= d1_reg;  z2_reg <= z1_reg;   p2_reg <= p1_reg;
        sq_reg <= {13'd0, sq_full[31:13]};
        b_reg  <= asr(mul32({2'd0, p1_reg[31:2]}, p8), 13);
        d3_reg <= d2_reg;  z3_reg <= z2_reg;   p3_reg <= p2_reg;
        a_reg  <= asr(mul32(p9, sq_reg), 12) + b_reg + p7;
        out_data <= d3_reg;
        if (d3_reg.pressure_valid && !z3_reg)
            out_data.pressure <= p3_reg + asr(a_reg, 4);
        else
            out_data.pressure <= '0;
    end

endmodule

`default_nettype wire

// File: rtl/env_sensor_compensation.sv
// ----------------------------------------------------------------------------
// env_sensor_compensation
// Integer compensation of raw temperature, pressure and humidity readings.
// ----------------------------------------------------------------------------
// Usage:
//   Write calibration words and channel_enable through the cfg port
//   (cfg_valid/cfg_ready, cfg_index, cfg_data); cfg_ready is always high.
//   Raise start with one reading beat on in_data; the beat is taken when
//   busy is low. busy never rises: a new beat may enter every cycle.
//   Each beat yields exactly one result beat on out_data, flagged by
//   done for a single cycle. Pipeline: 12 front stages (temperature,
//   t_fine, humidity, pressure operands), 33 divider stages (an input
//   register, then one quotient bit per stage), 4 stages of pressure
//   correction. Throughput: one beat per cycle.
//   The receiver cannot stall; results are never held back.
//   Reset: all pipeline valid bits drop, channel_enable returns to all
//   channels on and calibration words to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module env_sensor_compensation (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire esc_pkg::esc_in_t   in_data,
    output logic                    done,
    output esc_pkg::esc_out_t       out_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [63:0]        cfg_data
);
    import esc_pkg::*;

    logic [2:0]  enable_reg;
    logic [47:0] calib_temp_reg, calib_mixed_reg;
    logic [63:0] calib_press_low_reg, calib_press_high_reg;
    logic [31:0] calib_hum_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // hold the register bank; drop writes to unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg           <= 3'd7;
            calib_temp_reg       <= '0;
            calib_press_low_reg  <= '0;
            calib_press_high_reg <= '0;
            calib_mixed_reg      <= '0;
            calib_hum_reg        <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_CHANNEL_ENABLE:   enable_reg           <= cfg_data[2:0];
                REG_CALIB_TEMP:       calib_temp_reg       <= cfg_data[47:0];
                REG_CALIB_PRESS_LOW:  calib_press_low_reg  <= cfg_data;
                REG_CALIB_PRESS_HIGH: calib_press_high_reg <= cfg_data;
                REG_CALIB_MIXED:      calib_mixed_reg      <= cfg_data[47:0];
                REG_CALIB_HUM:        calib_hum_reg        <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    logic        f_valid, big_p;
    esc_out_t    f_data;
    logic [31:0] dividend, divisor;

    esc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (start),
        .in_data         (in_data),
        .enable          (enable_reg),
        .calib_temp      (calib_temp_reg),
        .calib_press_low (calib_press_low_reg),
        .calib_mixed     (calib_mixed_reg),
        .calib_hum       (calib_hum_reg),
        .p56_in          ({{16{calib_press_high_reg[31]}}, calib_press_high_reg[31:16],
                           {16{calib_press_high_reg[15]}}, calib_press_high_reg[15:0]}),
        .out_valid       (f_valid),
        .out_data        (f_data),
        .dividend        (dividend),
        .divisor         (divisor),
        .big_p           (big_p)
    );

    // advance side data alongside the divider
    esc_out_t    side_reg [0:DivStages-1];
    logic        bp_reg   [0:DivStages-1];
    logic        z_reg    [0:DivStages-1];
    logic        q_valid;
    logic [31:0] quotient;

    always_ff @(posedge clk)
    begin
        side_reg[0] <= f_data;
        bp_reg[0]   <= big_p;
        z_reg[0]    <= (divisor == '0);
        for (int i = 1; i < DivStages; i++)
        begin
            side_reg[i] <= side_reg[i-1];
            bp_reg[i]   <= bp_reg[i-1];
            z_reg[i]    <= z_reg[i-1];
        end
    end

    esc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .dividend  (dividend),
        .divisor   (divisor),
        .out_valid (q_valid),
        .quotient  (quotient)
    );

    esc_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (q_valid),
        .in_data          (side_reg[DivStages-1]),
        .big_p            (bp_reg[DivStages-1]),
        .div_zero         (z_reg[DivStages-1]),
        .quotient         (quotient),
        .calib_press_high (calib_press_high_reg),
        .calib_p9         (calib_mixed_reg[15:0]),
        .out_valid        (done),
        .out_data         (out_data)
    );

endmodule

`default_nettype wire
